[src/rtks_pkg.sv]
// Package for the row top-k select block: sizes, codes and float ordering helpers.
// Used by every module in src/.
package rtks_pkg;

   localparam int MaxKeep     = 16;
   localparam int MaxColumns  = 65536;
   localparam int SlotW       = $clog2(MaxKeep);
   localparam int KeepW       = 5;
   localparam int ColW        = 17;
   localparam int CntW        = $clog2(MaxColumns + 1);
   localparam int QueueDepth  = 4;
   localparam int QueuePtrW   = $clog2(QueueDepth);

   localparam logic [31:0]     PosInfBits = 32'h7F80_0000;
   localparam logic [31:0]     NegInfBits = 32'hFF80_0000;
   localparam logic [ColW-1:0] EmptyCol   = {ColW{1'b1}};

   localparam logic [1:0] StatusOk    = 2'd0;
   localparam logic [1:0] StatusShort = 2'd1;
   localparam logic [1:0] StatusOver  = 2'd2;

   localparam logic CsrKeepCount    = 1'b0;
   localparam logic CsrLargestFirst = 1'b1;

   // one classified element passed from front to back
   typedef struct packed {
      logic            can_enter;  // not NaN and not beyond capacity
      logic [31:0]     key;        // monotone order key
      logic [31:0]     bits;
      logic [ColW-1:0] column;
      logic            last;
      logic [1:0]      status;     // valid only when last
   } elem_type;

   function automatic logic [31:0] order_key(input logic [31:0] b);
      logic [31:0] v;
      v = (b[30:0] == 31'd0) ? 32'd0 : b;
      return v[31] ? ~v : (v | 32'h8000_0000);
   endfunction

   function automatic logic is_nan(input logic [31:0] b);
      return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
   endfunction

endpackage

[src/row_topk_select_core.sv]
// Top level of the row top-k select block: config registers, front, queue, back.
// Depends on rtks_pkg, rtks_front, rtks_queue, rtks_back.
//
// Usage: stream binary32 row elements on req_ (tdata = sample, tlast = row end).
// The front end classifies an element in its accept cycle and pushes it into the
// queue; from there the back end inserts it with one compare per kept slot in
// parallel, so one element per cycle is sustained inside a row. A row end puts
// the back end into a drain of its k kept slots, one result per cycle on rsp_
// while the receiver is ready, best first; during the drain the front keeps
// taking elements of the next row until the 4-entry queue fills.
// With an empty queue the row-end element passes through the queue, the drain
// state and the result register before the first result is valid.
// rsp_tuser carries the row status on every result; rsp_tlast marks the k-th.
// Reset (synchronous) loads keep_count 1, largest-first mode and empty lists.
// A stalled receiver holds the result register; the drain waits and, once
// the queue is full, req_tready drops. CSR writes belong in idle periods; any
// write discards the row in progress and restarts it with the new mode's sentinel.
module row_topk_select_core import rtks_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // sample_bits
   input  logic        req_tlast,   // row_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // kept_bits[31:0], kept_column[48:32], zero pad
   output logic        rsp_tlast,   // run_end
   output logic [1:0]  rsp_tuser,   // row_status
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [4:0]  csr_wdata
);

   logic [KeepW-1:0] keep_ff;
   logic             largest_ff;
   logic [KeepW-1:0] keep_eff;
   logic             f_valid, f_ready, b_valid, b_ready;
   elem_type         f_elem, b_elem;
   logic [31:0]      r_bits;
   logic [ColW-1:0]  r_col;

   always_comb begin
      if (keep_ff == '0)
         keep_eff = KeepW'(1);
      else if (keep_ff > KeepW'(MaxKeep))
         keep_eff = KeepW'(MaxKeep);
      else
         keep_eff = keep_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff    <= KeepW'(1);
         largest_ff <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrKeepCount:    keep_ff    <= csr_wdata;
            CsrLargestFirst: largest_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   rtks_front u_front (
      .clock, .reset, .row_clear(csr_we), .keep_eff,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_bits(req_tdata),
      .in_last(req_tlast), .out_valid(f_valid), .out_ready(f_ready), .out_elem(f_elem)
   );

   rtks_queue u_queue (
      .clock, .reset, .flush(csr_we),
      .wr_valid(f_valid), .wr_ready(f_ready), .wr_elem(f_elem),
      .rd_valid(b_valid), .rd_ready(b_ready), .rd_elem(b_elem)
   );

   // clear uses the mode being written so the sentinel matches
   rtks_back u_back (
      .clock, .reset, .row_clear(csr_we),
      .largest((csr_we && csr_index == CsrLargestFirst) ? csr_wdata[0] : largest_ff),
      .keep_eff,
      .in_valid(b_valid), .in_ready(b_ready), .in_elem(b_elem),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp_bits(r_bits),
      .rsp_column(r_col), .rsp_last(rsp_tlast), .rsp_status(rsp_tuser)
   );

   assign rsp_tdata = {7'd0, r_col, r_bits};

endmodule

[src/rtks_front.sv]
// Front end: accepts elements, counts columns, computes order keys and row status.
// Depends on rtks_pkg.
module rtks_front import rtks_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             row_clear,
   input  logic [KeepW-1:0] keep_eff,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [31:0]      in_bits,
   input  logic             in_last,
   output logic             out_valid,
   input  logic             out_ready,
   output elem_type         out_elem
);

   logic [CntW-1:0] count_ff, count_in;
   logic            over_ff, over_in;
   logic            full;
   logic            take;
   logic [CntW-1:0] count_after;
   logic            over_after;

   assign in_ready  = out_ready;
   assign out_valid = in_valid;
   assign take      = in_valid && out_ready;
   assign full      = (count_ff >= CntW'(MaxColumns));

   always_comb begin
      count_after = full ? count_ff : count_ff + CntW'(1);
      over_after  = over_ff || full;
      out_elem.can_enter = !full && !is_nan(in_bits);
      out_elem.key       = order_key(in_bits);
      out_elem.bits      = in_bits;
      out_elem.column    = ColW'(count_ff);
      out_elem.last      = in_last;
      if (over_after)
         out_elem.status = StatusOver;
      else if (count_after < CntW'(keep_eff))
         out_elem.status = StatusShort;
      else
         out_elem.status = StatusOk;
   end

   always_comb begin
      count_in = count_ff;
      over_in  = over_ff;
      if (row_clear) begin
         count_in = '0;
         over_in  = 1'b0;
      end else if (take) begin
         count_in = in_last ? '0 : count_after;
         over_in  = in_last ? 1'b0 : over_after;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         over_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         over_ff  <= over_in;
      end
   end

endmodule

[src/rtks_queue.sv]
// Small FIFO between front and back ends holding classified elements.
// Depends on rtks_pkg.
module rtks_queue import rtks_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     flush,
   input  logic     wr_valid,
   output logic     wr_ready,
   input  elem_type wr_elem,
   output logic     rd_valid,
   input  logic     rd_ready,
   output elem_type rd_elem
);

   elem_type             mem_ff [QueueDepth];
   logic [QueuePtrW-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [QueuePtrW:0]   fill_ff, fill_in;
   logic                 push, pop;

   assign wr_ready = (fill_ff != (QueuePtrW+1)'(QueueDepth));
   assign rd_valid = (fill_ff != '0);
   assign rd_elem  = mem_ff[rptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wptr_in = push ? wptr_ff + QueuePtrW'(1) : wptr_ff;
      rptr_in = pop  ? rptr_ff + QueuePtrW'(1) : rptr_ff;
      fill_in = fill_ff + (QueuePtrW+1)'(push) - (QueuePtrW+1)'(pop);
      if (flush) begin
         wptr_in = '0;
         rptr_in = '0;
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= wr_elem;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

endmodule

[src/rtks_back.sv]
// Back end: parallel compare-and-shift insertion list and row-end drain.
// Depends on rtks_pkg.
module rtks_back import rtks_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             row_clear,
   input  logic             largest,
   input  logic [KeepW-1:0] keep_eff,
   input  logic             in_valid,
   output logic             in_ready,
   input  elem_type         in_elem,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [31:0]      rsp_bits,
   output logic [ColW-1:0]  rsp_column,
   output logic             rsp_last,
   output logic [1:0]       rsp_status
);

   localparam logic StIns   = 1'b0;
   localparam logic StDrain = 1'b1;

   logic [31:0]     val_ff [MaxKeep];
   logic [31:0]     val_in [MaxKeep];
   logic [ColW-1:0] col_ff [MaxKeep];
   logic [ColW-1:0] col_in [MaxKeep];
   logic            state_ff, state_in;
   logic [SlotW-1:0] idx_ff, idx_in;
   logic [1:0]      status_ff, status_in;
   logic            ovalid_ff, ovalid_in;
   logic [31:0]     obits_ff, obits_in;
   logic [ColW-1:0] ocol_ff, ocol_in;
   logic            olast_ff, olast_in;
   logic [1:0]      ostat_ff, ostat_in;
   logic [MaxKeep-1:0] better;
   logic [31:0]     sentinel;
   logic [SlotW-1:0] klast;
   logic            take, slot_free, enter;

   assign sentinel  = largest ? NegInfBits : PosInfBits;
   assign klast     = SlotW'(keep_eff - KeepW'(1));
   assign in_ready  = (state_ff == StIns) && !row_clear;
   assign take      = in_valid && in_ready;
   assign slot_free = !ovalid_ff || rsp_ready;

   always_comb begin
      for (int i = 0; i < MaxKeep; i++) begin
         better[i] = largest ? (in_elem.key > order_key(val_ff[i]))
                             : (in_elem.key < order_key(val_ff[i]));
      end
      enter = in_elem.can_enter && better[klast];
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      status_in = status_ff;
      ovalid_in = ovalid_ff && !rsp_ready;
      obits_in  = obits_ff;
      ocol_in   = ocol_ff;
      olast_in  = olast_ff;
      ostat_in  = ostat_ff;
      for (int i = 0; i < MaxKeep; i++) begin
         val_in[i] = val_ff[i];
         col_in[i] = col_ff[i];
      end
      if (row_clear) begin
         for (int i = 0; i < MaxKeep; i++) begin
            val_in[i] = sentinel;
            col_in[i] = EmptyCol;
         end
         state_in = StIns;
      end else begin
         unique case (state_ff)
            StIns: begin
               if (take) begin
                  if (enter) begin
                     // slot i takes the element if better here and not above; else shifts down
                     for (int i = 0; i < MaxKeep; i++) begin
                        if (SlotW'(i) <= klast && better[i]) begin
                           if (i == 0 || !better[(i == 0) ? 0 : i-1]) begin
                              val_in[i] = in_elem.bits;
                              col_in[i] = in_elem.column;
                           end else begin
                              val_in[i] = val_ff[(i == 0) ? 0 : i-1];
                              col_in[i] = col_ff[(i == 0) ? 0 : i-1];
                           end
                        end
                     end
                  end
                  if (in_elem.last) begin
                     state_in  = StDrain;
                     idx_in    = '0;
                     status_in = in_elem.status;
                  end
               end
            end
            StDrain: begin
               if (slot_free) begin
                  ovalid_in = 1'b1;
                  obits_in  = val_ff[idx_ff];
                  ocol_in   = col_ff[idx_ff];
                  olast_in  = (idx_ff == klast);
                  ostat_in  = status_ff;
                  idx_in    = idx_ff + SlotW'(1);
                  if (idx_ff == klast) begin
                     state_in = StIns;
                     for (int i = 0; i < MaxKeep; i++) begin
                        val_in[i] = sentinel;
                        col_in[i] = EmptyCol;
                     end
                  end
               end
            end
            default: state_in = StIns;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= StIns;
         ovalid_ff <= 1'b0;
         for (int i = 0; i < MaxKeep; i++) begin
            val_ff[i] <= NegInfBits;
            col_ff[i] <= EmptyCol;
         end
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
         for (int i = 0; i < MaxKeep; i++) begin
            val_ff[i] <= val_in[i];
            col_ff[i] <= col_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      status_ff <= status_in;
      obits_ff  <= obits_in;
      ocol_ff   <= ocol_in;
      olast_ff  <= olast_in;
      ostat_ff  <= ostat_in;
   end

   assign rsp_valid  = ovalid_ff;
   assign rsp_bits   = obits_ff;
   assign rsp_column = ocol_ff;
   assign rsp_last   = olast_ff;
   assign rsp_status = ostat_ff;

endmodule

[src/row_topk_select_core_chk.sv]
// Port-level checker for row_topk_select_core, with its bind.
// Depends on rtks_pkg.
module row_topk_select_core_chk import rtks_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [1:0]  rsp_tuser
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 2'd3)
      else $error("bad row status");

   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[55:49] == 7'd0)
      else $error("pad bits set");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[48:32] == EmptyCol |->
         rsp_tdata[31:0] == PosInfBits || rsp_tdata[31:0] == NegInfBits)
      else $error("empty slot without sentinel");

endmodule

bind row_topk_select_core row_topk_select_core_chk u_chk (.*);
